@@ design/dtyp_pkg.sv @@
// Shared types and constants for the direction to yaw/pitch pipeline.
// No dependencies; used by every module of the block.
package dtyp_pkg;

    localparam int DW         = 64;
    localparam int AW         = 26;
    localparam int UW         = 25;
    localparam int SQRT_STEPS = 32;
    localparam int RAD_GUARD  = 28;
    localparam int TAB_LEN    = 30;

    localparam logic signed [AW-1:0] DEG_90  = AW'(90 * 32768);
    localparam logic [UW-1:0]        U_90    = UW'(90 * 32768);
    localparam logic [UW-1:0]        U_180   = UW'(180 * 32768);
    localparam logic [UW-1:0]        U_360   = UW'(360 * 32768);
    localparam logic [16:0]          OUT_90  = 17'd11520;
    localparam logic [16:0]          OUT_270 = 17'd34560;
    localparam logic [16:0]          OUT_MAX = 17'd46079;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic z_neg;
        logic z_pos;
        logic xy_zero;
        logic ax_zero;
        logic ay_zero;
        logic az_zero;
    } flags_t;

    typedef struct packed {
        logic [DW-1:0] m;
        logic [DW-1:0] res;
        logic [DW-1:0] yx;
        logic [DW-1:0] yy;
        logic [DW-1:0] pz;
        flags_t        f;
    } sq_t;

    typedef struct packed {
        logic signed [DW-1:0] yx;
        logic signed [DW-1:0] yy;
        logic signed [AW-1:0] ya;
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        logic signed [AW-1:0] pa;
        flags_t               f;
    } cd_t;

    typedef struct packed {
        logic [UW-1:0] yaw_ang;
        logic [UW-1:0] pit_ang;
        logic          xy_zero;
        logic          z_pos;
    } fin_t;

    function automatic logic signed [AW-1:0] atan_entry(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = AW'(1474560);
            1:  v = AW'(870484);
            2:  v = AW'(459940);
            3:  v = AW'(233473);
            4:  v = AW'(117189);
            5:  v = AW'(58652);
            6:  v = AW'(29333);
            7:  v = AW'(14667);
            8:  v = AW'(7334);
            9:  v = AW'(3667);
            10: v = AW'(1833);
            11: v = AW'(917);
            12: v = AW'(458);
            13: v = AW'(229);
            14: v = AW'(115);
            15: v = AW'(57);
            16: v = AW'(29);
            17: v = AW'(14);
            18: v = AW'(7);
            19: v = AW'(4);
            20: v = AW'(2);
            21: v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/dtyp_prep.sv @@
// Front end: absolute values and signs, squares, radius-squared and CORDIC operands.
// Three register stages; depends on dtyp_pkg.
module dtyp_prep #(
    parameter int COMP_WIDTH = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       vin,
    input  logic signed [COMP_WIDTH-1:0] dir_x,
    input  logic signed [COMP_WIDTH-1:0] dir_y,
    input  logic signed [COMP_WIDTH-1:0] dir_z,
    output logic                       vout,
    output dtyp_pkg::sq_t              dout
);
    localparam int CW       = COMP_WIDTH;
    localparam int PRE_SH   = 60 - CW;
    localparam int SQ_SHIFT = 2 * (32 - CW);

    logic               v1_reg, v2_reg, v3_reg;
    logic [CW-1:0]      ax1_reg, ay1_reg, az1_reg;
    dtyp_pkg::flags_t   f1_reg, f2_reg;
    logic [CW-1:0]      ax2_reg, ay2_reg, az2_reg;
    logic [2*CW-1:0]    sqx2_reg, sqy2_reg;
    dtyp_pkg::sq_t      d3_reg;

    logic [CW-1:0]      ax_next, ay_next, az_next;
    dtyp_pkg::flags_t   f_next;
    logic [2*CW:0]      n_sum;
    dtyp_pkg::sq_t      d3_next;

    always_comb
    begin
        ax_next = dir_x[CW-1] ? (~dir_x + 1'b1) : dir_x;
        ay_next = dir_y[CW-1] ? (~dir_y + 1'b1) : dir_y;
        az_next = dir_z[CW-1] ? (~dir_z + 1'b1) : dir_z;
        f_next.x_neg   = dir_x[CW-1];
        f_next.y_neg   = dir_y[CW-1];
        f_next.z_neg   = dir_z[CW-1];
        f_next.z_pos   = !dir_z[CW-1] && (dir_z != '0);
        f_next.xy_zero = (dir_x == '0) && (dir_y == '0);
        f_next.ax_zero = (dir_x == '0);
        f_next.ay_zero = (dir_y == '0);
        f_next.az_zero = (dir_z == '0);
    end

    always_comb
    begin
        n_sum      = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        d3_next.m   = dtyp_pkg::DW'(n_sum) << SQ_SHIFT;
        d3_next.res = '0;
        d3_next.yx  = dtyp_pkg::DW'(ax2_reg) << PRE_SH;
        d3_next.yy  = dtyp_pkg::DW'(ay2_reg) << PRE_SH;
        d3_next.pz  = dtyp_pkg::DW'(az2_reg) << PRE_SH;
        d3_next.f   = f2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg  <= ax_next;
            ay1_reg  <= ay_next;
            az1_reg  <= az_next;
            f1_reg   <= f_next;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            az2_reg  <= az1_reg;
            sqx2_reg <= ax1_reg * ax1_reg;
            sqy2_reg <= ay1_reg * ay1_reg;
            f2_reg   <= f1_reg;
            d3_reg   <= d3_next;
        end
    end

    assign vout = v3_reg;
    assign dout = d3_reg;
endmodule

@@ design/dtyp_sqrt_stage.sv @@
// One bit of the restoring integer square root of the radius squared.
// Depends on dtyp_pkg.
module dtyp_sqrt_stage #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  dtyp_pkg::sq_t din,
    output logic          vout,
    output dtyp_pkg::sq_t dout
);
    localparam logic [dtyp_pkg::DW-1:0] BIT = dtyp_pkg::DW'(1) << (62 - 2 * STEP);

    logic               v_reg;
    dtyp_pkg::sq_t      d_reg, d_next;
    logic [dtyp_pkg::DW-1:0] trial;

    always_comb
    begin
        trial  = din.res + BIT;
        d_next = din;
        if (din.m >= trial)
        begin
            d_next.m   = din.m - trial;
            d_next.res = (din.res >> 1) + BIT;
        end
        else
        begin
            d_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;
endmodule

@@ design/dtyp_cordic_stage.sv @@
// One CORDIC vectoring micro-rotation for both the yaw and the pitch angle.
// Depends on dtyp_pkg.
module dtyp_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  dtyp_pkg::cd_t din,
    output logic          vout,
    output dtyp_pkg::cd_t dout
);
    localparam logic signed [dtyp_pkg::AW-1:0] ATAN = dtyp_pkg::atan_entry(STEP);

    logic          v_reg;
    dtyp_pkg::cd_t d_reg, d_next;

    always_comb
    begin
        d_next = din;
        if (din.yy > 0)
        begin
            d_next.yx = din.yx + (din.yy >>> STEP);
            d_next.yy = din.yy - (din.yx >>> STEP);
            d_next.ya = din.ya + ATAN;
        end
        else
        begin
            d_next.yx = din.yx - (din.yy >>> STEP);
            d_next.yy = din.yy + (din.yx >>> STEP);
            d_next.ya = din.ya - ATAN;
        end
        if (din.py > 0)
        begin
            d_next.px = din.px + (din.py >>> STEP);
            d_next.py = din.py - (din.px >>> STEP);
            d_next.pa = din.pa + ATAN;
        end
        else
        begin
            d_next.px = din.px - (din.py >>> STEP);
            d_next.py = din.py + (din.px >>> STEP);
            d_next.pa = din.pa - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;
endmodule

@@ design/dtyp_finish.sv @@
// Back end: clamp, quadrant restore, rounding to 1/128 degree, saturation, negation.
// Two register stages, the second being the output register; depends on dtyp_pkg.
module dtyp_finish (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  dtyp_pkg::cd_t din,
    output logic          vout,
    output logic [15:0]   yaw_out,
    output logic [16:0]   neg_pitch_out
);
    logic               v1_reg, v2_reg;
    dtyp_pkg::fin_t     f_reg, f_next;
    logic [15:0]        yaw_reg, yaw_next;
    logic [16:0]        neg_reg, neg_next;
    logic [dtyp_pkg::UW-1:0] a, b;
    logic [17:0]        qy, qp;
    logic [16:0]        pit;

    function automatic logic [dtyp_pkg::UW-1:0] clamp(input logic signed [dtyp_pkg::AW-1:0] z);
        logic [dtyp_pkg::UW-1:0] r;
        if (z < 0)
            r = '0;
        else if (z > dtyp_pkg::DEG_90)
            r = dtyp_pkg::U_90;
        else
            r = z[dtyp_pkg::UW-1:0];
        return r;
    endfunction

    always_comb
    begin
        if (din.f.ay_zero)
            a = '0;
        else if (din.f.ax_zero)
            a = dtyp_pkg::U_90;
        else
            a = clamp(din.ya);
        b = din.f.az_zero ? '0 : clamp(din.pa);
        if (!din.f.x_neg)
            f_next.yaw_ang = din.f.y_neg ? (dtyp_pkg::U_360 - a) : a;
        else
            f_next.yaw_ang = din.f.y_neg ? (dtyp_pkg::U_180 + a) : (dtyp_pkg::U_180 - a);
        f_next.pit_ang = din.f.z_neg ? (dtyp_pkg::U_360 - b) : b;
        f_next.xy_zero = din.f.xy_zero;
        f_next.z_pos   = din.f.z_pos;
    end

    always_comb
    begin
        qy = 18'((f_reg.yaw_ang + 25'd128) >> 8);
        qp = 18'((f_reg.pit_ang + 25'd128) >> 8);
        if (f_reg.xy_zero)
        begin
            yaw_next = '0;
            pit      = f_reg.z_pos ? dtyp_pkg::OUT_90 : dtyp_pkg::OUT_270;
        end
        else
        begin
            yaw_next = (qy > 18'(dtyp_pkg::OUT_MAX)) ? dtyp_pkg::OUT_MAX[15:0] : qy[15:0];
            pit      = (qp > 18'(dtyp_pkg::OUT_MAX)) ? dtyp_pkg::OUT_MAX : qp[16:0];
        end
        neg_next = ~pit + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg   <= f_next;
            yaw_reg <= yaw_next;
            neg_reg <= neg_next;
        end
    end

    assign vout          = v2_reg;
    assign yaw_out       = yaw_reg;
    assign neg_pitch_out = neg_reg;
endmodule

@@ design/direction_to_yaw_pitch.sv @@
// Converts a direction vector into yaw and negated pitch in 1/128 degree, one
// vector per clock. The pipeline has three front-end stages, a
// 32-stage square root, one CORDIC stage per step for both angles, and two
// finishing stages ending in the output register. The whole pipeline holds
// while a result waits and m_tready is low.
// Depends on dtyp_pkg and the dtyp_* stage modules.
module direction_to_yaw_pitch #(
    parameter int COMP_WIDTH   = 24,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // dir_x, dir_y, dir_z from bit 0, zero fill to bytes
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // yaw_out [15:0], neg_pitch_out [32:16], zero fill to bit 39
    output logic [39:0]                     m_tdata
);
    localparam int CW = COMP_WIDTH;
    localparam int NS = dtyp_pkg::SQRT_STEPS;
    localparam int NC = CORDIC_STEPS;

    logic          en;
    logic          sq_v [0:NS];
    dtyp_pkg::sq_t sq_d [0:NS];
    logic          cd_v [0:NC];
    dtyp_pkg::cd_t cd_d [0:NC];
    logic [15:0]   yaw;
    logic [16:0]   negp;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    dtyp_prep #(.COMP_WIDTH(CW)) u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (s_tvalid),
        .dir_x (s_tdata[CW-1:0]),
        .dir_y (s_tdata[2*CW-1:CW]),
        .dir_z (s_tdata[3*CW-1:2*CW]),
        .vout  (sq_v[0]),
        .dout  (sq_d[0])
    );

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        dtyp_sqrt_stage #(.STEP(k)) u_sq (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (sq_v[k]),
            .din   (sq_d[k]),
            .vout  (sq_v[k+1]),
            .dout  (sq_d[k+1])
        );
    end

    always_comb
    begin
        cd_v[0]    = sq_v[NS];
        cd_d[0].yx = sq_d[NS].yx;
        cd_d[0].yy = sq_d[NS].yy;
        cd_d[0].ya = '0;
        cd_d[0].px = sq_d[NS].res << dtyp_pkg::RAD_GUARD;
        cd_d[0].py = sq_d[NS].pz;
        cd_d[0].pa = '0;
        cd_d[0].f  = sq_d[NS].f;
    end

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        dtyp_cordic_stage #(.STEP(i)) u_cd (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (cd_v[i]),
            .din   (cd_d[i]),
            .vout  (cd_v[i+1]),
            .dout  (cd_d[i+1])
        );
    end

    dtyp_finish u_fin (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .vin           (cd_v[NC]),
        .din           (cd_d[NC]),
        .vout          (m_tvalid),
        .yaw_out       (yaw),
        .neg_pitch_out (negp)
    );

    assign m_tdata = {7'b0, negp, yaw};
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for direction_to_yaw_pitch: streams direction vectors,
// predicts yaw and negated pitch with a CORDIC model and compares each transfer.
// Depends on the direction_to_yaw_pitch RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CW    = 24;
    localparam int STEPS = 18;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [15:0] yaw;
        logic [16:0] neg_pitch;
    } angles_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    angles_t angles_due[$];
    int      error_count = 0;
    int      sent = 0;
    int      checked = 0;
    int      cycles = 0;

    direction_to_yaw_pitch #(.COMP_WIDTH(CW), .CORDIC_STEPS(STEPS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic longint atan_step(int i);
        case (i)
            0: return 1474560;   1: return 870484;   2: return 459940;
            3: return 233473;    4: return 117189;   5: return 58652;
            6: return 29333;     7: return 14667;    8: return 7334;
            9: return 3667;      10: return 1833;    11: return 917;
            12: return 458;      13: return 229;     14: return 115;
            15: return 57;       16: return 29;      17: return 14;
            18: return 7;        19: return 4;       20: return 2;
            21: return 1;
            default: return 0;
        endcase
    endfunction

    // first-quadrant angle in 1/32768 degree
    function automatic longint first_quadrant(longint px, longint py);
        longint cx, cy, ang, dx, dy;
        cx = px; cy = py; ang = 0;
        if (py == 0) return 0;
        if (px == 0) return 90 * 32768;
        for (int i = 0; i < STEPS && i < 30; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx += dx; cy -= dy; ang += atan_step(i);
            end
            else
            begin
                cx -= dx; cy += dy; ang -= atan_step(i);
            end
        end
        if (ang < 0) ang = 0;
        if (ang > 90 * 32768) ang = 90 * 32768;
        return ang;
    endfunction

    function automatic longint root_floor(longint unsigned m);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > m) bitv >>= 2;
        while (bitv != 0)
        begin
            if (m >= res + bitv)
            begin
                m -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint to_units(longint ang);
        longint q;
        if (ang < 0) ang = 0;
        q = (ang + 128) >>> 8;
        return (q > 46079) ? 46079 : q;
    endfunction

    function automatic angles_t predict_angles(logic signed [23:0] dx,
                                               logic signed [23:0] dy,
                                               logic signed [23:0] dz);
        angles_t res;
        longint x, y, z, ax, ay, az, a, b, yaw_ang, pitch_ang, r, pitch;
        longint unsigned n;
        x = dx; y = dy; z = dz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        if (x == 0 && y == 0)
        begin
            res.yaw = '0;
            pitch = (z > 0) ? 11520 : 34560;
        end
        else
        begin
            a = first_quadrant(ax << (60 - CW), ay << (60 - CW));
            if (x >= 0) yaw_ang = (y >= 0) ? a : 360 * 32768 - a;
            else yaw_ang = (y >= 0) ? 180 * 32768 - a : 180 * 32768 + a;
            n = ax * ax + ay * ay;
            r = root_floor(n << (2 * (32 - CW)));
            b = first_quadrant(r << 28, az << (60 - CW));
            pitch_ang = (z >= 0) ? b : 360 * 32768 - b;
            res.yaw = 16'(to_units(yaw_ang));
            pitch = to_units(pitch_ang);
        end
        res.neg_pitch = 17'(-pitch);
        return res;
    endfunction

    task automatic report(string what, angles_t got, angles_t want);
        error_count++;
        $display("mismatch %s: got yaw %0d pitch %0d, want yaw %0d pitch %0d",
                 what, got.yaw, got.neg_pitch, want.yaw, want.neg_pitch);
    endtask

    // result side: random stall, then compare
    initial
    begin
        angles_t got, want;
        int stall;
        wait (rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got = {m_tdata[15:0], m_tdata[32:16]};
            checked++;
            if (angles_due.size() == 0)
                report("unexpected transfer", got, got);
            else
            begin
                want = angles_due.pop_front();
                if (got.yaw !== want.yaw) report("yaw", got, want);
                if (got.neg_pitch !== want.neg_pitch) report("pitch", got, want);
                if (m_tdata[39:33] !== '0) report("fill bits", got, want);
            end
        end
    end

    bit burst = 0;

    task automatic send_vector(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        angles_due.push_back(predict_angles(x, y, z));
        sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (angles_due.size() != 0) @(posedge clk);
    endtask

    task automatic test_extremes;
        logic [23:0] v[5] = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h000001, 24'hFFFFFF};
        send_vector(24'd0, 24'd0, 24'd0);
        send_vector(24'd0, 24'd0, 24'd5);
        send_vector(24'd0, 24'd0, 24'h800000);
        send_vector(24'd100, 24'd0, 24'd0);
        send_vector(24'd0, 24'd100, 24'd7);
        send_vector(24'd0, 24'hFFFF9C, 24'hFFFFF0);
        send_vector(24'hFFFF9C, 24'd0, 24'd3);
        send_vector(24'h7FFFFF, 24'hFFFFFF, 24'd0);
        send_vector(24'h7FFFFF, 24'hFFFFFE, 24'hFFFFFF);
        for (int i = 0; i < 12; i++)
            send_vector(v[$urandom_range(0, 4)], v[$urandom_range(0, 4)],
                        v[$urandom_range(0, 4)]);
    endtask

    task automatic test_random(int count);
        logic [23:0] x, y, z;
        for (int i = 0; i < count; i++)
        begin
            burst = ($urandom_range(0, 9) < 2);
            x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
            case ($urandom_range(0, 5))
                0: x = 24'($urandom_range(0, 7) - 3);
                1: y = 24'($urandom_range(0, 3) - 1);
                2: z = 24'd0;
                3: begin x = 24'(($urandom_range(0, 400)) - 200); y = 24'(($urandom_range(0, 400)) - 200); end
                default: ;
            endcase
            send_vector(x, y, z);
        end
        burst = 0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        drain();
        test_random(700);
        drain();
        test_random(720);
        drain();
        repeat (80) @(posedge clk);
        $display("sent %0d vectors, checked %0d transfers incl. axis and sign corners",
                 sent, checked);
        if (error_count == 0 && angles_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ direction_to_yaw_pitch.f @@
design/dtyp_pkg.sv
design/dtyp_prep.sv
design/dtyp_sqrt_stage.sv
design/dtyp_cordic_stage.sv
design/dtyp_finish.sv
design/direction_to_yaw_pitch.sv
bench/testbench.sv
